FILE: rtl/lnc_pkg.sv
// Shared types and constants for the LFSR noise voice.
`default_nettype none

package lnc_pkg;

   // Request operation codes
   typedef enum logic [1:0] {
      OP_TICK  = 2'd0,
      OP_READ  = 2'd1,
      OP_WRITE = 2'd2
   } opcode_type;

   // Register selects
   typedef enum logic [1:0] {
      REG_LENGTH   = 2'd0,
      REG_ENVELOPE = 2'd1,
      REG_NOISE    = 2'd2,
      REG_CONTROL  = 2'd3
   } reg_sel_type;

   localparam int LNC_NOISE_TICK_DIV = 4;

   localparam logic [14:0] LFSR_SEED     = 15'h7fff;
   localparam logic [7:0]  CTRL_READ_OR  = 8'hbf;
   localparam logic [7:0]  LENGTH_READ   = 8'hff;
   localparam logic [6:0]  LENGTH_FULL   = 7'd64;
   localparam logic [2:0]  ENV_CLK_STEP  = 3'd7;

   // One request as held in the input register
   typedef struct packed {
      logic [1:0] opcode;
      logic [1:0] reg_select;
      logic [7:0] write_data;
      logic       frame_edge;
   } req_type;

   // One response
   typedef struct packed {
      logic [7:0] read_data;
      logic [3:0] sample;
      logic       channel_active;
   } rsp_type;

endpackage

`default_nettype wire

FILE: rtl/lnc_voice.sv
// Voice state and per-request update: sequencer, length, envelope, LFSR.
`default_nettype none

module lnc_voice
   import lnc_pkg::*;
#(
   parameter int NOISE_TICK_DIV = LNC_NOISE_TICK_DIV
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    step_en,
   input  wire req_type req,
   output rsp_type      rsp
);

   localparam int PHASE_W = (NOISE_TICK_DIV > 1) ? $clog2(NOISE_TICK_DIV) : 1;
   localparam logic [PHASE_W:0] PHASE_DIV = (PHASE_W + 1)'(NOISE_TICK_DIV);

   logic [2:0]         seq_ff,      seq_in;
   logic [7:0]         env_set_ff,  env_set_in;
   logic [7:0]         noise_set_ff, noise_set_in;
   logic [7:0]         ctrl_ff,     ctrl_in;
   logic               trig_ff,     trig_in;
   logic               len_on_ff,   len_on_in;
   logic [6:0]         len_ff,      len_in;
   logic               voice_ff,    voice_in;
   logic [3:0]         vol_ff,      vol_in;
   logic [2:0]         env_per_ff,  env_per_in;
   logic [2:0]         env_cd_ff,   env_cd_in;
   logic               env_up_ff,   env_up_in;
   logic [14:0]        sr_ff,       sr_in;
   logic [19:0]        nc_ff,       nc_in;
   logic [PHASE_W-1:0] phase_ff,    phase_in;

   logic        length_clk;
   logic        env_clk;
   logic        noise_clk;
   logic        fb;
   logic [14:0] sr_shift;
   logic [4:0]  shamt;
   logic [19:0] reload;
   logic [7:0]  rd;
   logic [3:0]  smp;

   // Noise timer reload value from the noise clock register
   always_comb begin
      shamt = {1'b0, noise_set_ff[7:4]} + 5'd1;
      if (noise_set_ff[2:0] == 3'd0) begin
         reload = 20'd1 << shamt;
      end else begin
         reload = {17'd0, noise_set_ff[2:0]} << (shamt + 5'd1);
      end
   end

   // Next state and response for the current request
   always_comb begin
      seq_in       = seq_ff;
      env_set_in   = env_set_ff;
      noise_set_in = noise_set_ff;
      ctrl_in      = ctrl_ff;
      trig_in      = trig_ff;
      len_on_in    = len_on_ff;
      len_in       = len_ff;
      voice_in     = voice_ff;
      vol_in       = vol_ff;
      env_per_in   = env_per_ff;
      env_cd_in    = env_cd_ff;
      env_up_in    = env_up_ff;
      sr_in        = sr_ff;
      nc_in        = nc_ff;
      phase_in     = phase_ff;
      length_clk   = 1'b0;
      env_clk      = 1'b0;
      noise_clk    = 1'b0;
      fb           = 1'b0;
      sr_shift     = sr_ff;
      rd           = 8'd0;
      smp          = 4'd0;

      case (opcode_type'(req.opcode))
         OP_TICK: begin
            // frame sequencer
            if (req.frame_edge) begin
               seq_in     = seq_ff + 3'd1;
               length_clk = ~seq_in[0];
               env_clk    = (seq_in == ENV_CLK_STEP);
            end
            // tick divider for the noise timer
            if (({1'b0, phase_ff} + 1'b1) >= PHASE_DIV) begin
               phase_in = '0;
            end else begin
               phase_in = phase_ff + 1'b1;
            end
            noise_clk = (phase_in == '0);

            if (env_set_ff[7:3] == 5'd0) begin
               // DAC off
               voice_in = 1'b0;
            end else begin
               if (trig_ff) begin
                  trig_in    = 1'b0;
                  voice_in   = 1'b1;
                  vol_in     = env_set_ff[7:4];
                  env_per_in = env_set_ff[2:0];
                  env_cd_in  = env_set_ff[2:0];
                  env_up_in  = env_set_ff[3];
                  sr_in      = LFSR_SEED;
                  nc_in      = 20'd0;
               end
               if (length_clk && len_on_ff && len_ff != 7'd0) begin
                  len_in = len_ff - 7'd1;
                  if (len_in == 7'd0) begin
                     voice_in = 1'b0;
                  end
               end
               if (voice_in) begin
                  // volume envelope
                  if (env_per_in != 3'd0 && env_clk) begin
                     env_cd_in = env_cd_in - 3'd1;
                     if (env_cd_in == 3'd0) begin
                        env_cd_in = env_per_in;
                        if (env_up_in) begin
                           if (vol_in != 4'd15) begin
                              vol_in = vol_in + 4'd1;
                           end
                        end else if (vol_in != 4'd0) begin
                           vol_in = vol_in - 4'd1;
                        end
                     end
                  end
                  // noise timer and LFSR
                  if (noise_clk) begin
                     if (nc_in == 20'd0) begin
                        fb       = sr_in[0] ^ sr_in[1];
                        sr_shift = {fb, sr_in[14:1]};
                        if (noise_set_ff[3]) begin
                           sr_shift[6] = fb;
                        end
                        sr_in = sr_shift;
                        nc_in = reload;
                     end else begin
                        nc_in = nc_in - 20'd1;
                     end
                  end
                  smp = sr_in[0] ? vol_in : 4'd0;
               end
            end
         end

         OP_READ: begin
            case (reg_sel_type'(req.reg_select))
               REG_LENGTH:   rd = LENGTH_READ;
               REG_ENVELOPE: rd = env_set_ff;
               REG_NOISE:    rd = noise_set_ff;
               REG_CONTROL:  rd = ctrl_ff | CTRL_READ_OR;
               default:      rd = 8'd0;
            endcase
         end

         OP_WRITE: begin
            case (reg_sel_type'(req.reg_select))
               REG_LENGTH:   len_in       = LENGTH_FULL - {1'b0, req.write_data[5:0]};
               REG_ENVELOPE: env_set_in   = req.write_data;
               REG_NOISE:    noise_set_in = req.write_data;
               REG_CONTROL: begin
                  ctrl_in = req.write_data;
                  // extra length clock when enabling on an even step
                  if (!seq_ff[0] && req.write_data[6] && !len_on_ff && len_ff != 7'd0) begin
                     len_in = len_ff - 7'd1;
                     if (len_in == 7'd0) begin
                        voice_in = 1'b0;
                     end
                  end
                  if (req.write_data[7] && len_on_ff && len_in == LENGTH_FULL) begin
                     len_in = LENGTH_FULL - 7'd1;
                  end
                  if (req.write_data[7] && len_in == 7'd0) begin
                     len_in = LENGTH_FULL;
                  end
                  len_on_in = req.write_data[6];
                  trig_in   = req.write_data[7];
               end
               default: begin
                  len_in = len_ff;
               end
            endcase
         end

         default: begin
            rd = 8'd0;
         end
      endcase
   end

   assign rsp.read_data      = rd;
   assign rsp.sample         = smp;
   assign rsp.channel_active = voice_in;

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff       <= 3'd7;
         env_set_ff   <= 8'd0;
         noise_set_ff <= 8'd0;
         ctrl_ff      <= 8'd0;
         trig_ff      <= 1'b0;
         len_on_ff    <= 1'b0;
         len_ff       <= 7'd0;
         voice_ff     <= 1'b0;
         vol_ff       <= 4'd0;
         env_per_ff   <= 3'd0;
         env_cd_ff    <= 3'd0;
         env_up_ff    <= 1'b0;
         sr_ff        <= 15'd0;
         nc_ff        <= 20'd0;
         phase_ff     <= '0;
      end else if (step_en) begin
         seq_ff       <= seq_in;
         env_set_ff   <= env_set_in;
         noise_set_ff <= noise_set_in;
         ctrl_ff      <= ctrl_in;
         trig_ff      <= trig_in;
         len_on_ff    <= len_on_in;
         len_ff       <= len_in;
         voice_ff     <= voice_in;
         vol_ff       <= vol_in;
         env_per_ff   <= env_per_in;
         env_cd_ff    <= env_cd_in;
         env_up_ff    <= env_up_in;
         sr_ff        <= sr_in;
         nc_ff        <= nc_in;
         phase_ff     <= phase_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/lfsr_noise_channel.sv
// Top level of the LFSR noise voice: input register, voice, response register.
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_stall  | opcode, reg_select, write_data, frame_edge
//   rsp     | out       | rsp_valid/rsp_stall  | read_data, sample, channel_active
//
// One request per cycle sustained while rsp_stall is low; each request passes the input
// register, then the response register, and its response is set by the single combinational
// update of the voice state between the two.
// Reset is synchronous and active high; it empties both registers and loads the
// voice state. A stalled response holds the response register; the input
// register can still take one request while it is empty, after which req_stall rises.
`default_nettype none

module lfsr_noise_channel
   import lnc_pkg::*;
#(
   parameter int NOISE_TICK_DIV = LNC_NOISE_TICK_DIV
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [1:0] req_opcode,
   input  wire logic [1:0] req_reg_select,
   input  wire logic [7:0] req_write_data,
   input  wire logic       req_frame_edge,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [7:0]      rsp_read_data,
   output logic [3:0]      rsp_sample,
   output logic            rsp_channel_active
);

   logic    in_vld_ff,  in_vld_in;
   req_type in_req_ff;
   logic    rsp_vld_ff, rsp_vld_in;
   rsp_type rsp_ff;
   rsp_type voice_rsp;
   logic    req_take;
   logic    advance;

   // Handshake control
   assign advance   = in_vld_ff && (!rsp_vld_ff || !rsp_stall);
   assign req_stall = in_vld_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      if (req_take) begin
         in_vld_in = 1'b1;
      end else if (advance) begin
         in_vld_in = 1'b0;
      end else begin
         in_vld_in = in_vld_ff;
      end
      if (advance) begin
         rsp_vld_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_vld_in = 1'b0;
      end else begin
         rsp_vld_in = rsp_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_req_ff.opcode     <= req_opcode;
         in_req_ff.reg_select <= req_reg_select;
         in_req_ff.write_data <= req_write_data;
         in_req_ff.frame_edge <= req_frame_edge;
      end
      if (advance) begin
         rsp_ff <= voice_rsp;
      end
   end

   lnc_voice #(
      .NOISE_TICK_DIV (NOISE_TICK_DIV)
   ) u_voice (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .req     (in_req_ff),
      .rsp     (voice_rsp)
   );

   assign rsp_valid          = rsp_vld_ff;
   assign rsp_read_data      = rsp_ff.read_data;
   assign rsp_sample         = rsp_ff.sample;
   assign rsp_channel_active = rsp_ff.channel_active;

endmodule

`default_nettype wire

FILE: rtl/lnc_checker.sv
// Port-level checks for the noise voice, bound to the top level.
`default_nettype none

module lnc_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic [7:0] rsp_read_data,
   input wire logic [3:0] rsp_sample,
   input wire logic       rsp_channel_active
);

   // reset empties the response register
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // a stalled response stays valid
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("response dropped while stalled");

   // a sounding sample needs an active voice
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_sample != 4'd0 |-> rsp_channel_active)
      else $error("nonzero sample from inactive voice");

   // read data and sample never both carry a value
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_read_data != 8'd0 |-> rsp_sample == 4'd0)
      else $error("read response with a sample");

endmodule

bind lfsr_noise_channel lnc_checker u_lnc_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_read_data      (rsp_read_data),
   .rsp_sample         (rsp_sample),
   .rsp_channel_active (rsp_channel_active)
);

`default_nettype wire

FILE: test/tb_lfsr_noise_channel.sv
// Testbench for the LFSR noise voice: directed and random requests checked against a predictor.
module tb_lfsr_noise_channel;
   timeunit 1ns;
   timeprecision 1ps;
   import lnc_pkg::*;

   // Opcode left unused by the package enum
   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int DRAIN_CYCLES = 10;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [1:0] req_opcode = OP_TICK;
   logic [1:0] req_reg_select = REG_LENGTH;
   logic [7:0] req_write_data = '0;
   logic       req_frame_edge = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_read_data;
   logic [3:0] rsp_sample;
   logic       rsp_channel_active;

   lfsr_noise_channel u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_opcode         (req_opcode),
      .req_reg_select     (req_reg_select),
      .req_write_data     (req_write_data),
      .req_frame_edge     (req_frame_edge),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_read_data      (rsp_read_data),
      .rsp_sample         (rsp_sample),
      .rsp_channel_active (rsp_channel_active)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Predicted voice state, at reset values
   logic [2:0]  seq_step       = 3'd7;
   logic [7:0]  env_reg        = '0;
   logic [7:0]  noise_reg      = '0;
   logic [7:0]  ctrl_reg       = '0;
   logic        trig_pend      = 1'b0;
   logic        len_en         = 1'b0;
   logic [6:0]  len_count      = '0;
   logic        voice_on       = 1'b0;
   logic [3:0]  volume         = '0;
   logic [2:0]  env_period     = '0;
   logic [2:0]  env_count      = '0;
   logic        env_up         = 1'b0;
   logic [14:0] lfsr           = '0;
   logic [19:0] noise_timer    = '0;
   logic [5:0]  tick_phase     = '0;

   rsp_type expected_rsps[$];
   int      fail_count = 0;
   int      item_count = 0;
   int      quiet_cycles = 0;
   logic    no_idle = 1'b0;

   // Control write: length enable, trigger request, extra length clock
   task automatic write_control(input logic [7:0] d);
      begin
         ctrl_reg = d;
         if (!seq_step[0] && d[6] && !len_en && len_count != 0) begin
            len_count = len_count - 7'd1;
            if (len_count == 0) voice_on = 1'b0;
         end
         if (d[7] && len_en && len_count == LENGTH_FULL) len_count = LENGTH_FULL - 7'd1;
         if (d[7] && len_count == 0) len_count = LENGTH_FULL;
         len_en = d[6];
         trig_pend = d[7];
      end
   endtask

   // One audio tick; returns the sample
   function automatic logic [3:0] voice_tick(input logic frame);
      logic        len_clk;
      logic        env_clk;
      logic        noise_clk;
      logic        fb;
      int          shamt;
      logic [31:0] period;
      begin
         len_clk = 1'b0;
         env_clk = 1'b0;
         if (frame) begin
            seq_step = seq_step + 3'd1;
            len_clk = !seq_step[0];
            env_clk = seq_step == ENV_CLK_STEP;
         end
         if (int'(tick_phase) + 1 >= LNC_NOISE_TICK_DIV) tick_phase = '0;
         else tick_phase = tick_phase + 6'd1;
         noise_clk = tick_phase == 0;

         // DAC off: voice silenced, trigger stays pending
         if (env_reg[7:3] == 0) begin
            voice_on = 1'b0;
            return 4'd0;
         end
         if (trig_pend) begin
            trig_pend = 1'b0;
            voice_on = 1'b1;
            volume = env_reg[7:4];
            env_period = env_reg[2:0];
            env_count = env_reg[2:0];
            env_up = env_reg[3];
            lfsr = LFSR_SEED;
            noise_timer = '0;
         end
         if (len_clk && len_en && len_count != 0) begin
            len_count = len_count - 7'd1;
            if (len_count == 0) voice_on = 1'b0;
         end
         if (!voice_on) return 4'd0;

         // Envelope, saturating at both ends
         if (env_period != 0 && env_clk) begin
            env_count = env_count - 3'd1;
            if (env_count == 0) begin
               env_count = env_period;
               if (env_up) begin
                  if (volume != 4'hf) volume = volume + 4'd1;
               end else if (volume != 0) begin
                  volume = volume - 4'd1;
               end
            end
         end

         // Noise timer and LFSR
         if (noise_clk) begin
            if (noise_timer == 0) begin
               fb = lfsr[0] ^ lfsr[1];
               lfsr = {fb, lfsr[14:1]};
               if (noise_reg[3]) lfsr[6] = fb;
               shamt = int'(noise_reg[7:4]) + 1;
               period = 32'd1 << shamt;
               if (noise_reg[2:0] == 0) period = period >> 1;
               else period = period * noise_reg[2:0];
               noise_timer = 20'(period * 2);
            end else begin
               noise_timer = noise_timer - 20'd1;
            end
         end
         return lfsr[0] ? volume : 4'd0;
      end
   endfunction

   // Work out the response of one accepted request and queue it
   task automatic predict_request(input req_type r);
      rsp_type o;
      begin
         o = '0;
         case (r.opcode)
            OP_TICK: o.sample = voice_tick(r.frame_edge);
            OP_READ: begin
               case (r.reg_select)
                  REG_LENGTH:   o.read_data = LENGTH_READ;
                  REG_ENVELOPE: o.read_data = env_reg;
                  REG_NOISE:    o.read_data = noise_reg;
                  REG_CONTROL:  o.read_data = ctrl_reg | CTRL_READ_OR;
                  default: ;
               endcase
            end
            OP_WRITE: begin
               case (r.reg_select)
                  REG_LENGTH:   len_count = LENGTH_FULL - {1'b0, r.write_data[5:0]};
                  REG_ENVELOPE: env_reg = r.write_data;
                  REG_NOISE:    noise_reg = r.write_data;
                  REG_CONTROL:  write_control(r.write_data);
                  default: ;
               endcase
            end
            default: ;
         endcase
         o.channel_active = voice_on;
         expected_rsps.push_back(o);
      end
   endtask

   // Response stall, raised at random about 6 percent of the time, never while no_idle is set
   always @(negedge clock) begin
      rsp_stall <= (!no_idle && !reset) ? ($urandom_range(0, 99) < 6) : 1'b0;
   end

   // Request prediction, response check and watchdog
   always @(posedge clock) begin : watch_channels
      req_type req_seen;
      rsp_type want;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            req_seen = {req_opcode, req_reg_select, req_write_data, req_frame_edge};
            predict_request(req_seen);
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsps.size() == 0) begin
               $error("response with no request pending");
               fail_count++;
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_read_data !== want.read_data) begin
                  $error("read_data: expected %0h, got %0h", want.read_data, rsp_read_data);
                  fail_count++;
               end
               if (rsp_sample !== want.sample) begin
                  $error("sample: expected %0d, got %0d", want.sample, rsp_sample);
                  fail_count++;
               end
               if (rsp_channel_active !== want.channel_active) begin
                  $error("channel_active: expected %0b, got %0b",
                         want.channel_active, rsp_channel_active);
                  fail_count++;
               end
            end
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   // Send one request, with an occasional gap before it
   task automatic send_request(input logic [1:0] op, input logic [1:0] sel,
                               input logic [7:0] data, input logic frame);
      int gap;
      begin
         @(negedge clock);
         if (!no_idle && $urandom_range(0, 99) < 6) begin
            gap = $urandom_range(1, 4);
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         req_valid      <= 1'b1;
         req_opcode     <= op;
         req_reg_select <= sel;
         req_write_data <= data;
         req_frame_edge <= frame;
         @(posedge clock);
         while (req_stall) @(posedge clock);
         item_count++;
      end
   endtask

   task automatic tick_req(input logic frame);
      send_request(OP_TICK, 2'($urandom_range(0, 3)), 8'($urandom), frame);
   endtask

   task automatic read_req(input logic [1:0] sel);
      send_request(OP_READ, sel, 8'($urandom), 1'b0);
   endtask

   task automatic write_req(input logic [1:0] sel, input logic [7:0] data);
      send_request(OP_WRITE, sel, data, 1'($urandom));
   endtask

   // Reset values of every register, read-back of envelope, noise and control, unused opcode
   task automatic test_register_access;
      begin
         read_req(REG_LENGTH);
         read_req(REG_ENVELOPE);
         read_req(REG_NOISE);
         read_req(REG_CONTROL);
         write_req(REG_ENVELOPE, 8'hff);
         read_req(REG_ENVELOPE);
         write_req(REG_NOISE, 8'hff);
         read_req(REG_NOISE);
         write_req(REG_CONTROL, 8'h3f);
         read_req(REG_CONTROL);
         send_request(OP_UNUSED, REG_CONTROL, 8'hff, 1'b1);
      end
   endtask

   // Trigger held while the DAC is off, carried out once it is on
   task automatic test_dac_and_trigger;
      begin
         write_req(REG_ENVELOPE, 8'h07);
         write_req(REG_CONTROL, 8'h80);
         tick_req(1'b0);
         write_req(REG_ENVELOPE, 8'hf9);
         tick_req(1'b1);
         tick_req(1'b0);
      end
   endtask

   // Length extremes, extra clock on enable, reload and 64-to-63 on trigger
   task automatic test_length_and_control;
      begin
         write_req(REG_LENGTH, 8'hff);
         write_req(REG_CONTROL, 8'h40);
         write_req(REG_CONTROL, 8'hc0);
         write_req(REG_CONTROL, 8'hc0);
         tick_req(1'b1);
         tick_req(1'b1);
         write_req(REG_LENGTH, 8'h00);
      end
   endtask

   // Set up the voice with random content, mostly sounding
   task automatic setup_voice;
      logic [7:0] env;
      logic [7:0] nz;
      logic [7:0] ln;
      logic [7:0] ct;
      begin
         env = 8'($urandom);
         if ($urandom_range(0, 9) != 0 && env[7:3] == 0) env[7:4] = 4'($urandom_range(1, 15));
         nz = 8'($urandom);
         if ($urandom_range(0, 3) != 0) begin
            nz[7:4] = '0;
            nz[2:0] = 3'($urandom_range(0, 1));
         end
         ln = 8'($urandom);
         if ($urandom_range(0, 1) != 0) ln[5:4] = 2'b11;
         ct = 8'($urandom);
         if ($urandom_range(0, 9) < 7) ct[7] = 1'b1;
         if ($urandom_range(0, 3) != 0) write_req(REG_ENVELOPE, env);
         if ($urandom_range(0, 3) != 0) write_req(REG_NOISE, nz);
         if ($urandom_range(0, 1) != 0) write_req(REG_LENGTH, ln);
         write_req(REG_CONTROL, ct);
      end
   endtask

   // Well-formed voice setups followed by runs of ticks with occasional reads
   task automatic test_random_voice;
      int stop_at;
      int run_len;
      begin
         stop_at = item_count + 400;
         no_idle = 1'b1;
         while (item_count < stop_at) begin
            if (item_count > stop_at - 280) no_idle = 1'b0;
            setup_voice();
            run_len = ($urandom_range(0, 3) == 0) ? $urandom_range(80, 200)
                                                  : $urandom_range(8, 40);
            repeat (run_len) begin
               if ($urandom_range(0, 9) == 0) read_req(2'($urandom_range(0, 3)));
               else tick_req(1'($urandom));
            end
         end
         no_idle = 1'b0;
      end
   endtask

   // Unstructured requests
   task automatic test_random_noise;
      begin
         repeat (100) begin
            send_request(2'($urandom_range(0, 2)), 2'($urandom_range(0, 3)),
                         8'($urandom), 1'($urandom));
         end
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_register_access();
      test_dac_and_trigger();
      test_length_and_control();
      test_random_voice();
      test_random_noise();
      @(negedge clock);
      req_valid <= 1'b0;
      wait (expected_rsps.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
